[rtl/sed_pkg.sv]
// Shared types and constants for the string escape decoder.
// No dependencies; the files that use it refer to it by scoped names.
package sed_pkg;

  // Character codes
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_NINE      = 8'h39;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_TAB       = 8'h09;

  // Decimal escape value stops gathering at this limit
  localparam int unsigned ValueLimit = 26;
  localparam int unsigned ValueW     = 9;

  // Result queue between front and back (depth is a power of two)
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // One queue entry: the one or two results caused by one input item
  typedef struct packed {
    logic       two;
    logic [7:0] byte0;
    logic       last0;
    logic [7:0] byte1;
    logic       last1;
  } sed_entry_t;

endpackage

[rtl/sed_in_if.sv]
// Input channel of the string escape decoder: one source byte per item.
// Depends on nothing.
interface sed_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

[rtl/sed_out_if.sv]
// Output channel of the string escape decoder: one decoded byte per item.
// Depends on nothing.
interface sed_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

[rtl/sed_front.sv]
// Front part: accepts source bytes, tracks escape state, forms result entries.
// Depends on sed_pkg and sed_in_if.
module sed_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  sed_in_if.sink            in_i,
  input  logic              full_i,
  output logic              push_o,
  output sed_pkg::sed_entry_t entry_o
);

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESCAPE = 2'd1,
    MODE_DIGITS = 2'd2
  } mode_e;

  mode_e                        mode_q, mode_d;
  logic [sed_pkg::ValueW-1:0]   pend_q, pend_d;
  logic                         accept;
  logic                         is_digit;
  logic [3:0]                   dval;
  logic [sed_pkg::ValueW-1:0]   next_val;
  logic                         emit0;
  logic [7:0]                   c;
  logic                         last;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign c          = in_i.in_byte;
  assign last       = in_i.in_last;

  // Classify the byte and extend the decimal value
  assign is_digit = (c >= sed_pkg::CH_ZERO) && (c <= sed_pkg::CH_NINE);
  assign dval     = 4'(c - sed_pkg::CH_ZERO);
  assign next_val = (pend_q << 3) + (pend_q << 1) + sed_pkg::ValueW'(dval);

  // Decode one byte: next state and the results it causes
  always_comb begin
    mode_d  = mode_q;
    pend_d  = pend_q;
    emit0   = 1'b0;
    entry_o = '0;
    case (mode_q)
      MODE_ESCAPE: begin
        mode_d = MODE_NORMAL;
        if (c == sed_pkg::CH_N) begin
          emit0 = 1'b1;
          entry_o.byte0 = sed_pkg::CH_LF;
          entry_o.last0 = last;
        end else if (c == sed_pkg::CH_R) begin
          emit0 = 1'b1;
          entry_o.byte0 = sed_pkg::CH_CR;
          entry_o.last0 = last;
        end else if (c == sed_pkg::CH_T) begin
          emit0 = 1'b1;
          entry_o.byte0 = sed_pkg::CH_TAB;
          entry_o.last0 = last;
        end else if (c == sed_pkg::CH_BACKSLASH) begin
          emit0 = 1'b1;
          entry_o.byte0 = sed_pkg::CH_BACKSLASH;
          entry_o.last0 = last;
        end else if (is_digit) begin
          if (last) begin
            emit0 = 1'b1;
            entry_o.byte0 = {4'd0, dval};
            entry_o.last0 = 1'b1;
            pend_d = '0;
          end else begin
            mode_d = MODE_DIGITS;
            pend_d = sed_pkg::ValueW'(dval);
          end
        end else begin
          // Unknown escape: backslash, then the byte itself
          emit0 = 1'b1;
          entry_o.two   = 1'b1;
          entry_o.byte0 = sed_pkg::CH_BACKSLASH;
          entry_o.last0 = 1'b0;
          entry_o.byte1 = c;
          entry_o.last1 = last;
        end
      end
      MODE_DIGITS: begin
        if (is_digit) begin
          if ((next_val >= sed_pkg::ValueW'(sed_pkg::ValueLimit)) || last) begin
            emit0 = 1'b1;
            entry_o.byte0 = next_val[7:0];
            entry_o.last0 = last;
            pend_d = '0;
            mode_d = MODE_NORMAL;
          end else begin
            pend_d = next_val;
          end
        end else begin
          // Flush the value, then handle the byte in normal mode
          emit0 = 1'b1;
          entry_o.byte0 = pend_q[7:0];
          entry_o.last0 = 1'b0;
          pend_d = '0;
          if (c == sed_pkg::CH_BACKSLASH && !last) begin
            mode_d = MODE_ESCAPE;
          end else begin
            mode_d = MODE_NORMAL;
            entry_o.two   = 1'b1;
            entry_o.byte1 = c;
            entry_o.last1 = last;
          end
        end
      end
      default: begin
        if (c == sed_pkg::CH_BACKSLASH && !last) begin
          mode_d = MODE_ESCAPE;
        end else begin
          mode_d = MODE_NORMAL;
          emit0 = 1'b1;
          entry_o.byte0 = c;
          entry_o.last0 = last;
        end
      end
    endcase
  end

  assign push_o = accept && emit0;

  // Advance decode state on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NORMAL;
      pend_q <= '0;
    end else if (accept) begin
      mode_q <= mode_d;
      pend_q <= pend_d;
    end
  end

`ifndef ASSERT_OFF
  // A string always ends with the decoder back in normal mode
  a_last_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last) |=> (mode_q == MODE_NORMAL && pend_q == '0))
    else $error("decode state not cleared after last byte");

  // A gathered value stays below the limit while more digits may follow
  a_pend_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_DIGITS) |-> (pend_q < sed_pkg::ValueW'(sed_pkg::ValueLimit)))
    else $error("pending value out of range");

  // A last byte always produces a result marked last
  a_last_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last) |-> (push_o && (entry_o.two ? entry_o.last1 : entry_o.last0)))
    else $error("last byte did not produce a final result");
`endif

endmodule

[rtl/sed_queue.sv]
// Result queue between front and back: holds entries of one or two bytes.
// Depends on sed_pkg.
module sed_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  sed_pkg::sed_entry_t entry_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output sed_pkg::sed_entry_t head_o
);

  sed_pkg::sed_entry_t                mem_q [sed_pkg::QueueDepth];
  logic [sed_pkg::QueuePtrW-1:0]      wr_ptr_q;
  logic [sed_pkg::QueuePtrW-1:0]      rd_ptr_q;
  logic [sed_pkg::QueueCntW-1:0]      cnt_q;

  assign full_o  = (cnt_q == sed_pkg::QueueCntW'(sed_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  // Move pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

[rtl/sed_back.sv]
// Back part: sends the one or two bytes of each queued entry in order.
// Depends on sed_pkg and sed_out_if.
module sed_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  sed_pkg::sed_entry_t head_i,
  output logic                pop_o,
  sed_out_if.source           out_o
);

  logic second_q;
  logic fire;

  assign out_o.valid    = !empty_i;
  assign out_o.out_byte = second_q ? head_i.byte1 : head_i.byte0;
  assign out_o.out_last = second_q ? head_i.last1 : head_i.last0;
  assign fire           = out_o.valid && out_o.ready;

  // Drop the entry once its final byte has been taken
  assign pop_o = fire && (second_q || !head_i.two);

  // Select first or second byte of the head entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      second_q <= 1'b0;
    end else if (fire) begin
      second_q <= head_i.two && !second_q;
    end
  end

endmodule

[rtl/string_escape_decoder_unit.sv]
// Top level of the string escape decoder: front, result queue and back.
// Depends on sed_pkg, sed_in_if, sed_out_if, sed_front, sed_queue, sed_back.
//
//   channel  dir  payload            handshake
//   in_i     in   in_byte, in_last   valid/ready
//   out_o    out  out_byte, out_last valid/ready
//
// One input byte is taken per cycle while the four-entry result queue has room.
// Each byte yields zero, one or two output bytes; the back sends one per cycle
// while out_o.ready is high, so the two results of one item go out in turn.
// Results reach the output through the registered result queue.
// Reset (rst_ni low) clears decode state and empties the queue.
// Output stalls back up through the queue to in_i.ready when it is full.
module string_escape_decoder_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  sed_in_if.sink    in_i,
  sed_out_if.source out_o
);

  logic                push;
  logic                pop;
  logic                full;
  logic                empty;
  sed_pkg::sed_entry_t entry;
  sed_pkg::sed_entry_t head;

  sed_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (entry)
  );

  sed_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  sed_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

[test/tb.sv]
// Testbench for string_escape_decoder_unit: directed rows, then random strings.
// Also needs sed_pkg, sed_in_if and sed_out_if; predicts decoded bytes on its own.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Decoder state kept by the predictor
  typedef enum logic [1:0] {
    DEC_PLAIN,
    DEC_ESCAPE,
    DEC_DIGITS
  } dec_mode_e;

  // How a stimulus row gets its expected bytes
  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_NONE,
    ROW_ONE
  } row_kind_e;

  typedef struct packed {
    logic [7:0] chr;
    logic       last;
  } dec_char_t;

  typedef struct packed {
    logic [7:0] chr;
    logic       last;
    row_kind_e  kind;
    logic [7:0] want_chr;
    logic       want_last;
  } src_row_t;

  localparam int unsigned RandomItems = 550;
  localparam int unsigned MaxReports  = 10;

  logic clk_i = 1'b0;
  logic rst_ni;

  sed_in_if  in_if ();
  sed_out_if out_if ();

  string_escape_decoder_unit dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  src_row_t  src_rows[$];
  dec_char_t expected_chars[$];
  dec_mode_e dec_mode;
  logic [8:0] dec_value;
  int unsigned accepted;
  int unsigned failures;

  always #5 clk_i = ~clk_i;

  task automatic add_row(input logic [7:0] chr, input logic last, input row_kind_e kind,
                         input logic [7:0] want_chr, input logic want_last);
    src_rows.push_back('{chr, last, kind, want_chr, want_last});
  endtask

  task automatic emit_char(input logic [7:0] chr, input logic last, input bit keep);
    if (keep) expected_chars.push_back('{chr, last});
  endtask

  // Advance the decoder by one source byte; queue its outputs when keep is set
  task automatic decode_step(input logic [7:0] c, input logic last, input bit keep);
    bit digit;
    bit plain;
    digit = (c >= sed_pkg::CH_ZERO) && (c <= sed_pkg::CH_NINE);
    plain = 1'b0;
    case (dec_mode)
      DEC_ESCAPE: begin
        dec_mode = DEC_PLAIN;
        if (c == sed_pkg::CH_N) emit_char(sed_pkg::CH_LF, last, keep);
        else if (c == sed_pkg::CH_R) emit_char(sed_pkg::CH_CR, last, keep);
        else if (c == sed_pkg::CH_T) emit_char(sed_pkg::CH_TAB, last, keep);
        else if (c == sed_pkg::CH_BACKSLASH) emit_char(sed_pkg::CH_BACKSLASH, last, keep);
        else if (digit) begin
          dec_value = {1'b0, c - sed_pkg::CH_ZERO};
          if (last) begin
            emit_char(dec_value[7:0], 1'b1, keep);
            dec_value = '0;
          end else begin
            dec_mode = DEC_DIGITS;
          end
        end else begin
          emit_char(sed_pkg::CH_BACKSLASH, 1'b0, keep);
          emit_char(c, last, keep);
        end
      end
      DEC_DIGITS: begin
        if (digit) begin
          dec_value = dec_value * 9'd10 + {1'b0, c - sed_pkg::CH_ZERO};
          if (dec_value >= sed_pkg::ValueLimit || last) begin
            emit_char(dec_value[7:0], last, keep);
            dec_value = '0;
            dec_mode  = DEC_PLAIN;
          end
        end else begin
          // Flush the gathered value, then treat the byte as plain text
          emit_char(dec_value[7:0], 1'b0, keep);
          dec_value = '0;
          plain     = 1'b1;
        end
      end
      default: plain = 1'b1;
    endcase
    if (plain) begin
      if (c == sed_pkg::CH_BACKSLASH && !last) begin
        dec_mode = DEC_ESCAPE;
      end else begin
        dec_mode = DEC_PLAIN;
        emit_char(c, last, keep);
      end
    end
  endtask

  task automatic note_failure(input string what, input dec_char_t want);
    failures++;
    if (failures <= MaxReports)
      $display("%0t: %s: expected byte %02h last %0b, got byte %02h last %0b",
               $realtime, what, want.chr, want.last, out_if.out_byte, out_if.out_last);
  endtask

  // Mostly no wait, with occasional long quiet stretches of back-to-back items
  function automatic int unsigned pick_gap(inout int unsigned quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) quiet = $urandom_range(10, 40);
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, 18);
  endfunction

  // Build one random string: raw bytes, mostly well-formed escapes, some broken ones
  task automatic add_random_string();
    logic [7:0] text[$];
    int unsigned tokens;
    int unsigned ndig;
    tokens = $urandom_range(1, 8);
    for (int t = 0; t < tokens; t++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: text.push_back(8'($urandom_range(0, 255)));
        4: begin
          text.push_back(sed_pkg::CH_BACKSLASH);
          case ($urandom_range(0, 3))
            0: text.push_back(sed_pkg::CH_N);
            1: text.push_back(sed_pkg::CH_R);
            2: text.push_back(sed_pkg::CH_T);
            default: text.push_back(sed_pkg::CH_BACKSLASH);
          endcase
        end
        5, 6, 7: begin
          text.push_back(sed_pkg::CH_BACKSLASH);
          ndig = $urandom_range(1, 4);
          // Steer toward the limit so the wide values show up
          if ($urandom_range(0, 1) == 0) begin
            text.push_back(sed_pkg::CH_ZERO + 8'd2);
            text.push_back(sed_pkg::CH_ZERO + 8'($urandom_range(4, 6)));
            ndig = $urandom_range(0, 2);
          end
          for (int d = 0; d < ndig; d++)
            text.push_back(sed_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
        end
        8: begin
          text.push_back(sed_pkg::CH_BACKSLASH);
          text.push_back(8'($urandom_range(0, 255)));
        end
        default: text.push_back(sed_pkg::CH_BACKSLASH);
      endcase
    end
    foreach (text[i]) add_row(text[i], i == text.size() - 1, ROW_PREDICT, 8'h00, 1'b0);
  endtask

  // Predict on every accepted source byte, check every accepted decoded byte
  always @(posedge clk_i) begin : monitor
    dec_char_t want;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        decode_step(in_if.in_byte, in_if.in_last, src_rows[accepted].kind == ROW_PREDICT);
        if (src_rows[accepted].kind == ROW_ONE)
          emit_char(src_rows[accepted].want_chr, src_rows[accepted].want_last, 1'b1);
        accepted++;
      end
      if (out_if.valid && out_if.ready) begin
        if (expected_chars.size() == 0) begin
          note_failure("unexpected output", '0);
        end else begin
          want = expected_chars.pop_front();
          if (out_if.out_byte !== want.chr || out_if.out_last !== want.last)
            note_failure("output mismatch", want);
        end
      end
    end
  end

  // Output side: hold ready low for a drawn number of cycles per item
  initial begin : sink_side
    int unsigned gap;
    int unsigned quiet;
    quiet = 0;
    out_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      gap = pick_gap(quiet);
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_if.valid) @(posedge clk_i);
    end
  end

  initial begin : source_side
    int unsigned gap;
    int unsigned quiet;
    int unsigned idx;
    dec_mode  = DEC_PLAIN;
    dec_value = '0;
    accepted  = 0;
    failures  = 0;
    quiet     = 0;
    rst_ni          <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.in_byte   <= '0;
    in_if.in_last   <= 1'b0;

    // Directed rows: extremes, every escape letter and the special cases
    add_row("A",                   1'b0, ROW_ONE,  "A",                   1'b0);
    add_row(8'h00,                 1'b0, ROW_ONE,  8'h00,                 1'b0);
    add_row(8'hFF,                 1'b1, ROW_ONE,  8'hFF,                 1'b1);
    add_row(sed_pkg::CH_BACKSLASH, 1'b0, ROW_NONE, 8'h00,                 1'b0);
    add_row(sed_pkg::CH_N,         1'b0, ROW_ONE,  sed_pkg::CH_LF,        1'b0);
    add_row(sed_pkg::CH_BACKSLASH, 1'b0, ROW_NONE, 8'h00,                 1'b0);
    add_row(sed_pkg::CH_R,         1'b0, ROW_ONE,  sed_pkg::CH_CR,        1'b0);
    add_row(sed_pkg::CH_BACKSLASH, 1'b0, ROW_NONE, 8'h00,                 1'b0);
    add_row(sed_pkg::CH_T,         1'b1, ROW_ONE,  sed_pkg::CH_TAB,       1'b1);
    add_row(sed_pkg::CH_BACKSLASH, 1'b0, ROW_NONE, 8'h00,                 1'b0);
    add_row(sed_pkg::CH_BACKSLASH, 1'b0, ROW_ONE,  sed_pkg::CH_BACKSLASH, 1'b0);
    // Value runs past the limit and is cut to eight bits
    add_row(sed_pkg::CH_BACKSLASH, 1'b0, ROW_NONE, 8'h00,                 1'b0);
    add_row("2",                   1'b0, ROW_NONE, 8'h00,                 1'b0);
    add_row("5",                   1'b0, ROW_NONE, 8'h00,                 1'b0);
    add_row("9",                   1'b0, ROW_PREDICT, 8'h00,              1'b0);
    // Non-digit ends a value: two bytes from one item
    add_row(sed_pkg::CH_BACKSLASH, 1'b0, ROW_NONE, 8'h00,                 1'b0);
    add_row("3",                   1'b0, ROW_NONE, 8'h00,                 1'b0);
    add_row("x",                   1'b0, ROW_PREDICT, 8'h00,              1'b0);
    // Unknown escape on the last byte
    add_row(sed_pkg::CH_BACKSLASH, 1'b0, ROW_NONE, 8'h00,                 1'b0);
    add_row("q",                   1'b1, ROW_PREDICT, 8'h00,              1'b0);
    // Lone backslash at the end of a string
    add_row(sed_pkg::CH_BACKSLASH, 1'b1, ROW_ONE,  sed_pkg::CH_BACKSLASH, 1'b1);
    // Value flushed by the end of a string
    add_row(sed_pkg::CH_BACKSLASH, 1'b0, ROW_NONE, 8'h00,                 1'b0);
    add_row("7",                   1'b1, ROW_PREDICT, 8'h00,              1'b0);
    add_row(sed_pkg::CH_BACKSLASH, 1'b0, ROW_NONE, 8'h00,                 1'b0);
    add_row("1",                   1'b0, ROW_NONE, 8'h00,                 1'b0);
    add_row("2",                   1'b0, ROW_NONE, 8'h00,                 1'b0);
    add_row(sed_pkg::CH_BACKSLASH, 1'b1, ROW_PREDICT, 8'h00,              1'b0);

    // Random part: random strings of escapes and text, with a share of raw noise
    idx = src_rows.size();
    while (src_rows.size() < idx + RandomItems) begin
      if ($urandom_range(0, 9) == 0)
        add_row(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), ROW_PREDICT, 8'h00, 1'b0);
      else
        add_random_string();
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Drive each row, keeping valid high across back-to-back items
    idx = 0;
    while (idx < src_rows.size()) begin
      gap = pick_gap(quiet);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_if.valid   <= 1'b1;
      in_if.in_byte <= src_rows[idx].chr;
      in_if.in_last <= src_rows[idx].last;
      @(posedge clk_i);
      while (!in_if.ready) @(posedge clk_i);
      idx++;
    end
    in_if.valid <= 1'b0;

    // Drain, then watch a little longer for stray output
    while (accepted < src_rows.size() || expected_chars.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    failures += expected_chars.size();

    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Stop a hung run
  initial begin : watchdog
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
